// File: rtl/srsi_pkg.sv
package srsi_pkg;

  localparam int CNT_W    = 17;
  localparam int SAMPLE_W = 32;
  localparam int STEP_W   = 32;
  localparam int SUM_W    = 52;
  localparam int TAIL_W   = 36;
  localparam int X_W      = 56;   // 8*S + 9*T or 12*S
  localparam int HALF_W   = 28;   // magnitude split for the step multiply
  localparam int PROD_W   = HALF_W + STEP_W;
  localparam int ACC_W    = X_W + STEP_W;
  localparam int RND_SH   = 27;   // step Q8.24 and 1/8 from the 1/24 scale
  localparam int V_W      = ACC_W - RND_SH;
  localparam int OUT_W    = 64;
  localparam int DATA_W   = 32;
  localparam int ADDR_W   = 3;

  localparam logic signed [SUM_W-1:0] SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
  localparam logic signed [SUM_W-1:0] SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};

  // Half of 3 * 2^27: rounds the final divide to nearest, ties away from zero.
  localparam logic [ACC_W-1:0] ROUND_BIAS = ACC_W'(3) << (RND_SH - 1);

  localparam logic [CNT_W-1:0]  COUNT_RESET = CNT_W'(1);
  localparam logic [STEP_W-1:0] STEP_RESET  = STEP_W'(32'h0100_0000);

  // Register index, taken from paddr[2].
  localparam logic REG_POINT_COUNT = 1'b0;
  localparam logic REG_GRID_STEP   = 1'b1;

  typedef enum logic [1:0] {
    MODE_ZERO = 2'd0,   // single point, result is zero
    MODE_TRAP = 2'd1,   // two points, trapezoid
    MODE_FULL = 2'd2    // Simpson with optional 3/8 tail
  } mode_e;

  // Finished run handed from the accumulator to the scaling pipeline.
  typedef struct packed {
    logic signed [SUM_W-1:0]  sum;
    logic signed [TAIL_W-1:0] tail;
    logic                     clip;
    mode_e                    mode;
    logic [STEP_W-1:0]        step;
  } run_t;

  // Sideband that rides along the divide stages.
  typedef struct packed {
    logic neg;
    logic clip;
  } side_t;

endpackage

// File: rtl/simpson_rule_stream_integrator_core.sv
// Channel  | Handshake                      | Payload
// ---------+--------------------------------+----------------------------------
// input    | in_valid_i / in_stall_o        | sample_i (Q16.16, signed)
// output   | out_valid_o / out_stall_i      | integral_o (Q48.16), saturated_o
// config   | psel/penable/pwrite, pready=1  | paddr, pwdata, prdata
//
// One item per cycle while in_stall_o is low: each sample is a single weighted accumulate.
// The last item of a run enters a 12-stage scaling pipeline (step multiply
// as two 28x32 partial products, divide by 3 as a shift-add reciprocal).
// Reset clears the run and loads point_count = 1 and grid_step = 1.0.
// in_stall_o rises only on the last item of a run while the pipeline is full and the output is stalled.
module simpson_rule_stream_integrator_core import srsi_pkg::*; #(
  parameter int MAX_POINTS = 65536
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,

  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic signed [SAMPLE_W-1:0] sample_i,

  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic signed [OUT_W-1:0]    integral_o,
  output logic                       saturated_o,

  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [ADDR_W-1:0]          paddr,
  input  logic [DATA_W-1:0]          pwdata,
  output logic [DATA_W-1:0]          prdata,
  output logic                       pready
);

  logic [CNT_W-1:0]  count_q;
  logic [STEP_W-1:0] step_q;
  logic              wr, wr_count, acc_ready;
  logic              run_valid, scale_ready, v_valid, div_ready;
  run_t              run;
  logic [V_W-1:0]    v;
  side_t             side;
  logic [OUT_W-1:0]  integral;

  // register file: point_count at 0x0, grid_step at 0x4
  assign pready   = 1'b1;
  assign wr       = psel && penable && pwrite && pready;
  assign wr_count = wr && (paddr[2] == REG_POINT_COUNT);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= COUNT_RESET;
      step_q  <= STEP_RESET;
    end else if (wr) begin
      case (paddr[2])
        REG_POINT_COUNT: count_q <= pwdata[CNT_W-1:0];
        REG_GRID_STEP:   step_q  <= pwdata[STEP_W-1:0];
        default:         ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      REG_POINT_COUNT: prdata = DATA_W'(count_q);
      REG_GRID_STEP:   prdata = DATA_W'(step_q);
      default:         prdata = '0;
    endcase
  end

  // a point_count write drops the run in progress
  srsi_acc #(
    .MAX_POINTS(MAX_POINTS)
  ) u_acc (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .clear_i    (wr_count),
    .count_i    (count_q),
    .step_i     (step_q),
    .in_valid_i (in_valid_i),
    .sample_i   (sample_i),
    .in_ready_o (acc_ready),
    .run_valid_o(run_valid),
    .run_o      (run),
    .run_ready_i(scale_ready)
  );

  assign in_stall_o = !acc_ready;

  srsi_scale u_scale (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (run_valid),
    .in_ready_o (scale_ready),
    .run_i      (run),
    .out_valid_o(v_valid),
    .out_ready_i(div_ready),
    .v_o        (v),
    .side_o     (side)
  );

  srsi_div3 u_div3 (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (v_valid),
    .in_ready_o (div_ready),
    .v_i        (v),
    .side_i     (side),
    .out_valid_o(out_valid_o),
    .out_ready_i(!out_stall_i),
    .integral_o (integral),
    .saturated_o(saturated_o)
  );

  assign integral_o = integral;

endmodule

// File: rtl/srsi_acc.sv
module srsi_acc import srsi_pkg::*; #(
  parameter int MAX_POINTS = 65536
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       clear_i,
  input  logic [CNT_W-1:0]           count_i,
  input  logic [STEP_W-1:0]          step_i,
  input  logic                       in_valid_i,
  input  logic signed [SAMPLE_W-1:0] sample_i,
  output logic                       in_ready_o,
  output logic                       run_valid_o,
  output run_t                       run_o,
  input  logic                       run_ready_i
);

  logic [CNT_W-1:0]         idx_q, idx_d;
  logic signed [SUM_W-1:0]  sum_q, sum_d, sum_new;
  logic signed [TAIL_W-1:0] tail_q, tail_d, tail_new;
  logic                     clip_q, clip_d, clip_new;

  logic [CNT_W-1:0] n, n_last, split, simp_last;
  logic             is_one, is_two, is_odd, even_big;
  logic             simp_en, tail_en, w_one, last, fire;
  logic [1:0]       tk;
  logic signed [SAMPLE_W+1:0] wval, tval;
  logic signed [SUM_W:0]      sum_ext;
  logic                       ovf;
  mode_e                      mode;

  // effective count, clamped to 1..MAX_POINTS
  always_comb begin
    if (count_i == '0) begin
      n = CNT_W'(1);
    end else if (32'(count_i) > MAX_POINTS) begin
      n = CNT_W'(MAX_POINTS);
    end else begin
      n = count_i;
    end
  end

  assign n_last    = n - CNT_W'(1);
  assign split     = n - CNT_W'(4);
  assign is_one    = (n == CNT_W'(1));
  assign is_two    = (n == CNT_W'(2));
  assign is_odd    = n[0];
  assign even_big  = !is_odd && !is_two;
  assign simp_last = is_odd ? n_last : split;

  assign simp_en = is_two || (is_odd && !is_one) ||
                   (even_big && (split != '0) && (idx_q <= split));
  assign tail_en = even_big && (idx_q >= split);
  assign tk      = idx_q[1:0] - split[1:0];

  // Simpson weight 1 at the ends, 4 on odd points, 2 on even points
  assign w_one = is_two || (idx_q == '0) || (idx_q == simp_last);

  always_comb begin
    if (w_one) begin
      wval = (SAMPLE_W+2)'(sample_i);
    end else if (idx_q[0]) begin
      wval = (SAMPLE_W+2)'(sample_i) <<< 2;
    end else begin
      wval = (SAMPLE_W+2)'(sample_i) <<< 1;
    end
  end

  // 3/8 weights 1,3,3,1
  always_comb begin
    if (tk == 2'd0 || tk == 2'd3) begin
      tval = (SAMPLE_W+2)'(sample_i);
    end else begin
      tval = (SAMPLE_W+2)'(sample_i) + ((SAMPLE_W+2)'(sample_i) <<< 1);
    end
  end

  assign sum_ext = (SUM_W+1)'(sum_q) + (SUM_W+1)'(wval);
  assign ovf     = sum_ext[SUM_W] != sum_ext[SUM_W-1];

  always_comb begin
    sum_new  = sum_q;
    clip_new = clip_q;
    if (simp_en) begin
      if (ovf) begin
        sum_new  = sum_ext[SUM_W] ? SUM_MIN : SUM_MAX;
        clip_new = 1'b1;
      end else begin
        sum_new = sum_ext[SUM_W-1:0];
      end
    end
  end

  assign tail_new = tail_en ? tail_q + TAIL_W'(tval) : tail_q;

  always_comb begin
    if (is_one) begin
      mode = MODE_ZERO;
    end else if (is_two) begin
      mode = MODE_TRAP;
    end else begin
      mode = MODE_FULL;
    end
  end

  assign last        = (idx_q == n_last);
  assign in_ready_o  = !last || run_ready_i;
  assign fire        = in_valid_i && in_ready_o;
  assign run_valid_o = in_valid_i && last;

  always_comb begin
    run_o.sum  = sum_new;
    run_o.tail = tail_new;
    run_o.clip = clip_new;
    run_o.mode = mode;
    run_o.step = step_i;
  end

  always_comb begin
    idx_d  = idx_q;
    sum_d  = sum_q;
    tail_d = tail_q;
    clip_d = clip_q;
    if (clear_i) begin
      idx_d  = '0;
      sum_d  = '0;
      tail_d = '0;
      clip_d = 1'b0;
    end else if (fire) begin
      if (last) begin
        idx_d  = '0;
        sum_d  = '0;
        tail_d = '0;
        clip_d = 1'b0;
      end else begin
        idx_d  = idx_q + CNT_W'(1);
        sum_d  = sum_new;
        tail_d = tail_new;
        clip_d = clip_new;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q  <= '0;
      sum_q  <= '0;
      tail_q <= '0;
      clip_q <= 1'b0;
    end else begin
      idx_q  <= idx_d;
      sum_q  <= sum_d;
      tail_q <= tail_d;
      clip_q <= clip_d;
    end
  end

endmodule

// File: rtl/srsi_scale.sv
module srsi_scale import srsi_pkg::*; (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  run_t           run_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output logic [V_W-1:0] v_o,
  output side_t          side_o
);

  localparam int NS = 5;

  logic [NS-1:0] vld_q;
  logic [NS:0]   rdy;

  // stage 1: run snapshot
  run_t s1_q;
  // stage 2: weighted sum X
  logic signed [X_W-1:0] x_q, x_d;
  logic                  s2_clip_q;
  logic [STEP_W-1:0]     s2_step_q;
  // stage 3: magnitude
  logic [X_W-1:0]        m_q;
  side_t                 s3_side_q;
  logic [STEP_W-1:0]     s3_step_q;
  // stage 4: partial products
  logic [PROD_W-1:0]     p0_q, p1_q;
  side_t                 s4_side_q;
  // stage 5: rounded, shifted product
  logic [V_W-1:0]        v_q;
  side_t                 s5_side_q;
  logic [ACC_W-1:0]      acc;

  always_comb begin
    rdy[NS] = out_ready_i;
    for (int k = NS - 1; k >= 0; k--) begin
      rdy[k] = !vld_q[k] || rdy[k+1];
    end
  end

  assign in_ready_o  = rdy[0];
  assign out_valid_o = vld_q[NS-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      for (int k = 0; k < NS; k++) begin
        if (rdy[k]) begin
          vld_q[k] <= (k == 0) ? in_valid_i : vld_q[(k == 0) ? 0 : k - 1];
        end
      end
    end
  end

  always_comb begin
    case (s1_q.mode)
      MODE_TRAP: x_d = (X_W'(s1_q.sum) <<< 3) + (X_W'(s1_q.sum) <<< 2);
      MODE_FULL: x_d = (X_W'(s1_q.sum) <<< 3) + (X_W'(s1_q.tail) <<< 3) + X_W'(s1_q.tail);
      default:   x_d = '0;
    endcase
  end

  assign acc = ACC_W'(p0_q) + (ACC_W'(p1_q) << HALF_W) + ROUND_BIAS;

  always_ff @(posedge clk_i) begin
    if (rdy[0]) begin
      s1_q <= run_i;
    end
    if (rdy[1]) begin
      x_q       <= x_d;
      s2_clip_q <= s1_q.clip;
      s2_step_q <= s1_q.step;
    end
    if (rdy[2]) begin
      m_q            <= x_q[X_W-1] ? X_W'(-x_q) : X_W'(x_q);
      s3_side_q.neg  <= x_q[X_W-1];
      s3_side_q.clip <= s2_clip_q;
      s3_step_q      <= s2_step_q;
    end
    if (rdy[3]) begin
      p0_q      <= PROD_W'(m_q[HALF_W-1:0]) * PROD_W'(s3_step_q);
      p1_q      <= PROD_W'(m_q[X_W-1:HALF_W]) * PROD_W'(s3_step_q);
      s4_side_q <= s3_side_q;
    end
    if (rdy[4]) begin
      v_q       <= acc[ACC_W-1:RND_SH];
      s5_side_q <= s4_side_q;
    end
  end

  assign v_o    = v_q;
  assign side_o = s5_side_q;

endmodule

// File: rtl/srsi_div3.sv
module srsi_div3 import srsi_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic [V_W-1:0]   v_i,
  input  side_t            side_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic [OUT_W-1:0] integral_o,
  output logic             saturated_o
);

  // v * (4^32 - 1) / 3 built as v * 5 * 17 * 257 * 65537 * (2^32 + 1);
  // the top bits give floor(v/3) or one less.
  localparam int Y1_W = V_W + 3;
  localparam int Y2_W = Y1_W + 5;
  localparam int Y3_W = Y2_W + 9;
  localparam int Y4_W = Y3_W + 17;
  localparam int Y5_W = Y4_W + 33;
  localparam int NS   = 7;

  logic [NS-1:0] vld_q;
  logic [NS:0]   rdy;

  logic [Y1_W-1:0]  y1_q;
  logic [Y2_W-1:0]  y2_q;
  logic [Y3_W-1:0]  y3_q;
  logic [Y4_W-1:0]  y4_q;
  logic [Y5_W-1:0]  y5;
  logic [V_W-1:0]   q0_q, q_q;
  logic [3:0]       lo_q [5];
  side_t            side_q [6];
  logic [3:0]       rem;
  logic [OUT_W-1:0] res_q;
  logic             sat_q;

  always_comb begin
    rdy[NS] = out_ready_i;
    for (int k = NS - 1; k >= 0; k--) begin
      rdy[k] = !vld_q[k] || rdy[k+1];
    end
  end

  assign in_ready_o  = rdy[0];
  assign out_valid_o = vld_q[NS-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      for (int k = 0; k < NS; k++) begin
        if (rdy[k]) begin
          vld_q[k] <= (k == 0) ? in_valid_i : vld_q[(k == 0) ? 0 : k - 1];
        end
      end
    end
  end

  assign y5 = Y5_W'(y4_q) + (Y5_W'(y4_q) << 32);

  // remainder is 0..3, so four low bits carry it exactly
  assign rem = lo_q[4] - (q0_q[3:0] + (q0_q[3:0] << 1));

  always_ff @(posedge clk_i) begin
    if (rdy[0]) begin
      y1_q      <= Y1_W'(v_i) + (Y1_W'(v_i) << 2);
      lo_q[0]   <= v_i[3:0];
      side_q[0] <= side_i;
    end
    if (rdy[1]) begin
      y2_q      <= Y2_W'(y1_q) + (Y2_W'(y1_q) << 4);
      lo_q[1]   <= lo_q[0];
      side_q[1] <= side_q[0];
    end
    if (rdy[2]) begin
      y3_q      <= Y3_W'(y2_q) + (Y3_W'(y2_q) << 8);
      lo_q[2]   <= lo_q[1];
      side_q[2] <= side_q[1];
    end
    if (rdy[3]) begin
      y4_q      <= Y4_W'(y3_q) + (Y4_W'(y3_q) << 16);
      lo_q[3]   <= lo_q[2];
      side_q[3] <= side_q[2];
    end
    if (rdy[4]) begin
      q0_q      <= y5[64 +: V_W];
      lo_q[4]   <= lo_q[3];
      side_q[4] <= side_q[3];
    end
    if (rdy[5]) begin
      q_q       <= q0_q + V_W'(rem >= 4'd3);
      side_q[5] <= side_q[4];
    end
    if (rdy[6]) begin
      res_q <= side_q[5].neg ? -OUT_W'(q_q) : OUT_W'(q_q);
      sat_q <= side_q[5].clip;
    end
  end

  assign integral_o  = res_q;
  assign saturated_o = sat_q;

endmodule
